// ===== hw/rtl/ohl_pkg.sv =====
package ohl_pkg;

    // List geometry
    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 32;

    // Fixed field widths of the channels
    localparam int REQ_TYPE_W = 2;
    localparam int POS_W      = 5;
    localparam int HANDLE_W   = 32;
    localparam int COUNT_W    = 5;

    // Derived widths
    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_READ   = 2'd2,
        REQ_REMOVE = 2'd3
    } req_type_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic exec;
    } ohl_cmd_t;

endpackage

// ===== hw/rtl/ohl_if.sv =====
interface ohl_req_if import ohl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POS_W-1:0]      position;
    logic [HANDLE_W-1:0]   handle_in;

    modport source (output valid, output req_type, output position, output handle_in,
                    input ready);
    modport sink   (input valid, input req_type, input position, input handle_in,
                    output ready);
endinterface

interface ohl_rsp_if import ohl_pkg::*;;
    logic                valid;
    logic                ready;
    logic                ok;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  count;
    logic                full_res;

    modport source (output valid, output ok, output handle_out, output count,
                    output full_res, input ready);
    modport sink   (input valid, input ok, input handle_out, input count,
                    input full_res, output ready);
endinterface

// ===== hw/rtl/ohl_ctrl.sv =====
module ohl_ctrl import ohl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ohl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // request executes on the accepting edge
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ohl_datapath.sv =====
module ohl_datapath import ohl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ohl_cmd_t              cmd,
    input  logic [REQ_TYPE_W-1:0] req_type,
    input  logic [POS_W-1:0]      position,
    input  logic [HANDLE_W-1:0]   handle_in,
    output logic                  ok,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic [COUNT_W-1:0]    count,
    output logic                  full_res
);

    logic [STORE_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               ok_reg;
    logic               ok_next;
    logic [STORE_W-1:0] hout_reg;
    logic [STORE_W-1:0] hout_next;

    req_type_t          rtype;
    logic               full;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   fill_ext;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   ins_idx;
    logic               do_insert;
    logic               do_remove;
    logic [STORE_W-1:0] h;

    assign rtype    = req_type_t'(req_type);
    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(position);
    assign fill_ext = CMP_W'(fill_reg);
    assign in_range = (pos_ext < fill_ext);
    assign idx      = pos_ext[IDX_W-1:0];
    assign h        = handle_in[STORE_W-1:0];

    always_comb
    begin
        ok_next   = 1'b0;
        hout_next = '0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        ins_idx   = idx;
        fill_next = fill_reg;
        unique case (rtype)
            REQ_APPEND:
            begin
                ok_next   = !full;
                do_insert = !full;
                ins_idx   = fill_reg[IDX_W-1:0];
            end
            REQ_INSERT:
            begin
                ok_next   = !full && (pos_ext <= fill_ext);
                do_insert = ok_next;
            end
            REQ_READ:
            begin
                ok_next = in_range;
                if (in_range)
                begin
                    hout_next = entries_reg[idx];
                end
            end
            REQ_REMOVE:
            begin
                ok_next   = in_range;
                do_remove = in_range;
                if (in_range)
                begin
                    hout_next = entries_reg[idx];
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (do_insert)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_remove)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Cells past the insert slot take lower; the remove slot and past it take upper
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [STORE_W-1:0] lower;
        logic [STORE_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = entries_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = entries_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
            begin
                priority if (do_insert && (IDX_W'(g) > ins_idx))
                begin
                    entries_reg[g] <= lower;
                end
                else if (do_insert && (IDX_W'(g) == ins_idx))
                begin
                    entries_reg[g] <= h;
                end
                else if (do_remove && (IDX_W'(g) >= idx))
                begin
                    entries_reg[g] <= upper;
                end
                else
                begin
                    entries_reg[g] <= entries_reg[g];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg   <= ok_next;
            hout_reg <= hout_next;
        end
    end

    assign ok         = ok_reg;
    assign handle_out = HANDLE_W'(hout_reg);
    assign count      = COUNT_W'(CMP_W'(fill_reg));
    assign full_res   = full;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_refused_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !ok_next |=> fill_reg == $past(fill_reg))
        else $error("refused request changed the fill count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && ok_next && rtype == REQ_APPEND
        |=> fill_reg == CNT_W'($past(fill_reg) + 1'b1))
        else $error("append did not grow the list by one");

    a_read_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && rtype == REQ_READ |=> fill_reg == $past(fill_reg))
        else $error("read changed the fill count");

endmodule

// ===== hw/rtl/ordered_handle_list.sv =====
// Ordered handle list: append, insert, read and remove on a chain of entry cells.
// The result word is valid on the cycle after the request word is accepted.
// Requests do not overlap: the two-state sequencer takes no new request word until the
// result word is taken (execute on accept, then hold the result until it is taken).
// Reset: the entry count clears to zero; entry contents are undefined until written.
module ordered_handle_list import ohl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ohl_req_if.sink   req,
    ohl_rsp_if.source rsp
);

    ohl_cmd_t cmd;

    ohl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    ohl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req.req_type),
        .position   (req.position),
        .handle_in  (req.handle_in),
        .ok         (rsp.ok),
        .handle_out (rsp.handle_out),
        .count      (rsp.count),
        .full_res   (rsp.full_res)
    );

endmodule
